>>> design/range_frame_parser_crc8_assert.svh
// assertion macros for the range frame parser checker
`ifndef RANGE_FRAME_PARSER_CRC8_ASSERT_SVH
`define RANGE_FRAME_PARSER_CRC8_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rfp_pkg.sv
// shared constants and types for the range frame parser
package rfp_pkg;

  localparam int MAX_CH      = 8;
  localparam int CH_W        = 3;
  localparam int POS_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int RANGE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY      = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'd84;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'd72;
  localparam logic [BYTE_W-1:0] CRC_POLY_RESET      = 8'd7;

  typedef enum logic [1:0] {
    OP_DIST_HI,
    OP_DIST_LO,
    OP_MASK,
    OP_FINAL
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] data;
    logic              good;
  } op_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

>>> design/rfp_queue.sv
// short request queue between the byte classifier and the frame assembler
module rfp_queue #(
  parameter int DEPTH = rfp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rfp_pkg::op_t       op_in,
  input  logic               pop,
  output rfp_pkg::op_t       op_out,
  output rfp_pkg::q_status_t status
);
  import rfp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             is_full;
  logic             is_valid;
  logic             do_push;
  logic             do_pop;

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_valid = (count != '0);
  assign status   = '{full: is_full, valid: is_valid};
  assign do_push  = push && !is_full;
  assign do_pop   = pop && is_valid;
  assign op_out   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/rfp_front.sv
// front end: header hunt, byte position tracking, crc and request classification
module rfp_front #(
  parameter int CHANNELS = rfp_pkg::MAX_CH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfp_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                             push,
  input  logic [rfp_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                             q_full,
  output logic                             q_push,
  output rfp_pkg::op_t                     q_op
);
  import rfp_pkg::*;

  localparam logic [POS_W-1:0] POS_MASK = POS_W'(2 + 2 * CHANNELS);
  localparam logic [POS_W-1:0] POS_CRC  = POS_W'(3 + 2 * CHANNELS);

  logic [BYTE_W-1:0] header_first;
  logic [BYTE_W-1:0] header_second;
  logic [BYTE_W-1:0] crc_poly;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  byte_position_next;
  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] running_crc_next;
  logic [BYTE_W-1:0] crc_stepped;
  logic [POS_W-1:0]  offset;
  logic [BYTE_W-1:0] want;
  logic              accept;

  function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ poly) : {c[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

  assign accept      = push && !q_full;
  assign crc_stepped = crc_step(running_crc, rx_byte, crc_poly);
  assign offset      = byte_position - POS_W'(2);
  assign want        = (byte_position == '0) ? header_first : header_second;

  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    q_push             = 1'b0;
    q_op.kind          = OP_DIST_HI;
    q_op.ch            = offset[CH_W:1];
    q_op.data          = rx_byte;
    q_op.good          = (rx_byte == running_crc);
    if (accept) begin
      priority if (byte_position < POS_W'(2)) begin
        if (rx_byte == want) begin
          running_crc_next   = crc_stepped;
          byte_position_next = byte_position + POS_W'(1);
        end
      end else if (byte_position < POS_MASK) begin
        q_push             = 1'b1;
        q_op.kind          = offset[0] ? OP_DIST_LO : OP_DIST_HI;
        running_crc_next   = crc_stepped;
        byte_position_next = byte_position + POS_W'(1);
      end else if (byte_position == POS_MASK) begin
        q_push             = 1'b1;
        q_op.kind          = OP_MASK;
        running_crc_next   = crc_stepped;
        byte_position_next = byte_position + POS_W'(1);
      end else if (byte_position == POS_CRC) begin
        q_push             = 1'b1;
        q_op.kind          = OP_FINAL;
        running_crc_next   = '0;
        byte_position_next = '0;
      end else begin
        running_crc_next   = '0;
        byte_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RESET;
      header_second <= HEADER_SECOND_RESET;
      crc_poly      <= CRC_POLY_RESET;
      byte_position <= '0;
      running_crc   <= '0;
    end else begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_HEADER_FIRST:  header_first  <= cfg_data;
          REG_HEADER_SECOND: header_second <= cfg_data;
          REG_CRC_POLY:      crc_poly      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> design/rfp_back.sv
// back end: distance and mask stores, result register
module rfp_back #(
  parameter int CHANNELS = rfp_pkg::MAX_CH
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_valid,
  input  rfp_pkg::op_t                                  q_op,
  output logic                                          q_pop,
  input  logic                                          pop,
  output logic                                          empty,
  output logic                                          frame_good,
  output logic [rfp_pkg::MAX_CH-1:0][rfp_pkg::RANGE_W-1:0] ranges,
  output logic [rfp_pkg::BYTE_W-1:0]                    mask
);
  import rfp_pkg::*;

  logic [MAX_CH-1:0][RANGE_W-1:0] dist_store;
  logic [BYTE_W-1:0]              mask_store;
  logic                           out_valid;
  logic                           is_final;

  assign is_final = (q_op.kind == OP_FINAL);
  assign q_pop    = q_valid && (!is_final || !out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (q_op.kind)
        OP_DIST_HI: dist_store[q_op.ch] <= {q_op.data, 8'h00};
        OP_DIST_LO: dist_store[q_op.ch] <= dist_store[q_op.ch] | {8'h00, q_op.data};
        OP_MASK:    mask_store <= q_op.data;
        OP_FINAL: begin
          frame_good <= q_op.good;
          for (int j = 0; j < MAX_CH; j++) begin
            ranges[j] <= (q_op.good && j < CHANNELS) ? dist_store[j] : '0;
          end
          mask <= q_op.good ? mask_store : '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && is_final) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> design/range_frame_parser_crc8.sv
// top level of the range frame parser with crc-8 check
// accepts one byte per cycle unless full; a four-entry request queue decouples classifier and assembler
// a result goes from its crc byte through a queue entry into the result register, waiting in the queue
// only while an earlier result is held; the classifier stops when the queue is full
// synchronous active-high reset clears position, crc, queue and result valid, loads default registers
module range_frame_parser_crc8 #(
  parameter int CHANNELS = rfp_pkg::MAX_CH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfp_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [rfp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic                          frame_good,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch0,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch1,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch2,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch3,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch4,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch5,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch6,
  output logic [rfp_pkg::RANGE_W-1:0]   range_ch7,
  output logic [rfp_pkg::BYTE_W-1:0]    channel_updated_mask
);
  import rfp_pkg::*;

  logic                           fe_push;
  op_t                            fe_op;
  op_t                            be_op;
  q_status_t                      q_status;
  logic                           be_pop;
  logic [MAX_CH-1:0][RANGE_W-1:0] ranges;

  assign full = q_status.full;

  rfp_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .rx_byte   (rx_byte),
    .q_full    (q_status.full),
    .q_push    (fe_push),
    .q_op      (fe_op)
  );

  rfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (fe_push),
    .op_in  (fe_op),
    .pop    (be_pop),
    .op_out (be_op),
    .status (q_status)
  );

  rfp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_status.valid),
    .q_op       (be_op),
    .q_pop      (be_pop),
    .pop        (pop),
    .empty      (empty),
    .frame_good (frame_good),
    .ranges     (ranges),
    .mask       (channel_updated_mask)
  );

  assign range_ch0 = ranges[0];
  assign range_ch1 = ranges[1];
  assign range_ch2 = ranges[2];
  assign range_ch3 = ranges[3];
  assign range_ch4 = ranges[4];
  assign range_ch5 = ranges[5];
  assign range_ch6 = ranges[6];
  assign range_ch7 = ranges[7];

endmodule

>>> design/rfp_checker.sv
// port-level checker for the range frame parser, bound to the top level
`include "range_frame_parser_crc8_assert.svh"

module rfp_checker #(
  parameter int CHANNELS = rfp_pkg::MAX_CH
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic                          frame_good,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch0,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch1,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch2,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch3,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch4,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch5,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch6,
  input logic [rfp_pkg::RANGE_W-1:0]   range_ch7,
  input logic [rfp_pkg::BYTE_W-1:0]    channel_updated_mask
);

  logic [8*rfp_pkg::RANGE_W+rfp_pkg::BYTE_W-1:0] payload;

  assign payload = {range_ch0, range_ch1, range_ch2, range_ch3, range_ch4, range_ch5,
                    range_ch6, range_ch7, channel_updated_mask};

  `RFP_ASSERT_IMPL(a_reset_idle, $past(rst), empty && !full, "not idle after reset")

  `RFP_ASSERT_IMPL(a_bad_frame_zero, !empty && !frame_good, payload == '0, "dropped frame carries data")

  `RFP_ASSERT_IMPL(a_unused_channel_zero, !empty, (CHANNELS > 7) || (range_ch7 == 0), "unused channel not zero")

  `RFP_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(frame_good) && $stable(payload), "waiting result changed")

endmodule

bind range_frame_parser_crc8 rfp_checker #(.CHANNELS(CHANNELS)) u_rfp_checker (.*);
